/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define PPDS_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PPDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ppds_pkg.sv */
// shared constants, codes and types of the pendulum drive sequencer
package ppds_pkg;

   // timing constants
   localparam int PRESCALE_LIMIT = 26;
   localparam int TICKS_PER_BEAT = 100;
   localparam int PRESCALE_W     = $clog2(PRESCALE_LIMIT + 1);
   localparam int BEAT_W         = $clog2(TICKS_PER_BEAT + 1);

   // drive constants
   localparam int STEP     = 3;
   localparam int DEADBAND = 10;

   // field widths
   localparam int PERIOD_W   = 15;
   localparam int TIME_W     = 14;
   localparam int FORCE_W    = 13;
   localparam int LEVEL_W    = 14;
   localparam int DUTY_W     = 13;
   localparam int TIMER_W    = 16;
   localparam int PUSH_W     = 7;
   localparam int PHASE_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // command codes
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SWING_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PULL_TIME     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TIME     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_TIME  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PULL_FORCE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_FORCE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_FORCE = 3'd6;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_NONE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_PULL    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
   localparam logic [PHASE_W-1:0] PH_OFF     = 3'd4;

   // configuration registers
   typedef struct packed {
      logic [PERIOD_W-1:0]       swing_period;
      logic [TIME_W-1:0]         pull_time;
      logic [TIME_W-1:0]         hold_time;
      logic [TIME_W-1:0]         release_time;
      logic signed [FORCE_W-1:0] pull_force;
      logic signed [FORCE_W-1:0] hold_force;
      logic signed [FORCE_W-1:0] release_force;
   } cfg_type;

   // one result word
   typedef struct packed {
      logic               drive_a;
      logic               drive_b;
      logic [DUTY_W-1:0]  duty;
      logic               heartbeat;
      logic [PHASE_W-1:0] phase;
   } result_type;

endpackage

/* rtl/ppds_req_if.sv */
// request channel: command words into the sequencer
interface ppds_req_if
   import ppds_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              command;
   logic [PUSH_W-1:0] push_every;

   modport source (output valid, output command, output push_every, input ready);
   modport sink (input valid, input command, input push_every, output ready);
endinterface

/* rtl/ppds_rsp_if.sv */
// response channel: bridge drive words out of the sequencer
interface ppds_rsp_if
   import ppds_pkg::*;
;
   logic               valid;
   logic               ready;
   logic               drive_a;
   logic               drive_b;
   logic [DUTY_W-1:0]  duty;
   logic               heartbeat;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, output drive_a, output drive_b, output duty,
                   output heartbeat, output phase, input ready);
   modport sink (input valid, input drive_a, input drive_b, input duty,
                 input heartbeat, input phase, output ready);
endinterface

/* rtl/pendulum_pulse_drive_sequencer.sv */
// top level of the pendulum pulse drive sequencer, one motor channel
//
//   channel    direction  word
//   req_chan   in         command, push_every
//   rsp_chan   out        drive_a, drive_b, duty, heartbeat, phase
//   csr_*      in         write enable, index, data (no read-back)
//
// A word accepted into the input register moves into the result register,
// where its response is valid, once the output is free; one word accepted
// per cycle while no response stalls. The whole state update is one pass of
// logic after the input register. Synchronous active-high reset clears the
// core state, the configuration registers and both valids. A stalled response
// holds while the input register still takes one more word behind it.
module pendulum_pulse_drive_sequencer
   import ppds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ppds_req_if.sink              req_chan,
   ppds_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg_ff;
   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [PUSH_W-1:0] in_every_ff;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;
   result_type        result;
   logic              out_free;
   logic              advance;

   // stage handshake
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign advance        = in_valid_ff & out_free;
   assign req_chan.ready = ~in_valid_ff | out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SWING_PERIOD:  cfg_ff.swing_period  <= csr_wdata[PERIOD_W-1:0];
            REG_PULL_TIME:     cfg_ff.pull_time     <= csr_wdata[TIME_W-1:0];
            REG_HOLD_TIME:     cfg_ff.hold_time     <= csr_wdata[TIME_W-1:0];
            REG_RELEASE_TIME:  cfg_ff.release_time  <= csr_wdata[TIME_W-1:0];
            REG_PULL_FORCE:    cfg_ff.pull_force    <= csr_wdata[FORCE_W-1:0];
            REG_HOLD_FORCE:    cfg_ff.hold_force    <= csr_wdata[FORCE_W-1:0];
            REG_RELEASE_FORCE: cfg_ff.release_force <= csr_wdata[FORCE_W-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_cmd_ff   <= req_chan.command;
         in_every_ff <= req_chan.push_every;
      end
   end

   ppds_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .command    (in_cmd_ff),
      .push_every (in_every_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.drive_a   = rsp_data_ff.drive_a;
   assign rsp_chan.drive_b   = rsp_data_ff.drive_b;
   assign rsp_chan.duty      = rsp_data_ff.duty;
   assign rsp_chan.heartbeat = rsp_data_ff.heartbeat;
   assign rsp_chan.phase     = rsp_data_ff.phase;

endmodule

/* rtl/ppds_core.sv */
// sequencer state and its single-pass next-state and result logic
module ppds_core
   import ppds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              command,
   input  logic [PUSH_W-1:0] push_every,
   input  cfg_type           cfg,
   output result_type        result
);

   localparam logic signed [LEVEL_W-1:0] BAND_POS = LEVEL_W'(DEADBAND);
   localparam logic signed [LEVEL_W-1:0] BAND_NEG = -BAND_POS;
   localparam logic [LEVEL_W-1:0]        STEP_V   = LEVEL_W'(STEP);
   localparam int                        SUM_W    = TIME_W + 3;

   logic [PRESCALE_W-1:0]     prescale_ff, prescale_in;
   logic [BEAT_W-1:0]         beat_ff, beat_in;
   logic [TIMER_W-1:0]        timer_ff, timer_in;
   logic [PUSH_W-1:0]         push_ff, push_in;
   logic                      armed_ff, armed_in;
   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic signed [FORCE_W-1:0] target_ff, target_in;
   logic signed [LEVEL_W-1:0] drive_ff, drive_in;
   logic [DUTY_W-1:0]         held_ff, held_in;
   logic                      led_ff, led_in;

   logic signed [LEVEL_W-1:0] target_ext;
   logic signed [LEVEL_W-1:0] drive_neg;
   logic [SUM_W-1:0]          end_hold;
   logic [SUM_W-1:0]          end_release;
   logic [SUM_W-1:0]          timer_wide;

   assign target_ext  = LEVEL_W'(target_ff);
   assign end_hold    = SUM_W'(cfg.pull_time) + SUM_W'(cfg.hold_time);
   assign end_release = end_hold + SUM_W'(cfg.release_time);
   assign drive_neg   = -drive_in;

   // next state for one word
   always_comb begin
      prescale_in = prescale_ff;
      beat_in     = beat_ff;
      timer_in    = timer_ff;
      push_in     = push_ff;
      armed_in    = armed_ff;
      phase_in    = phase_ff;
      target_in   = target_ff;
      drive_in    = drive_ff;
      led_in      = led_ff;
      timer_wide  = '0;
      if (command == CMD_TICK) begin
         if (prescale_ff == PRESCALE_W'(PRESCALE_LIMIT)) begin
            prescale_in = '0;
            // slow tick: saturating period timer
            if (timer_ff != '1) begin
               timer_in = timer_ff + 1'b1;
            end
            // level walks toward target
            if (drive_ff < target_ext) begin
               drive_in = drive_ff + STEP_V;
            end else if (drive_ff > target_ext) begin
               drive_in = drive_ff - STEP_V;
            end
            // heartbeat divider
            if (beat_ff == BEAT_W'(TICKS_PER_BEAT - 1)) begin
               beat_in = '0;
               led_in  = ~led_ff;
            end else begin
               beat_in = beat_ff + 1'b1;
            end
         end else begin
            prescale_in = prescale_ff + 1'b1;
         end
      end else begin
         // period expiry restarts the timer and counts pushes
         if (timer_ff >= TIMER_W'(cfg.swing_period)) begin
            timer_in = '0;
            armed_in = 1'b0;
            phase_in = PH_PULL;
            if (push_every != '0) begin
               push_in = push_ff + 1'b1;
               if (push_in >= push_every) begin
                  push_in  = '0;
                  armed_in = 1'b1;
               end
            end
         end
         timer_wide = SUM_W'(timer_in);
         // phase walk while armed
         if (armed_in) begin
            case (phase_in)
               PH_PULL: begin
                  target_in = cfg.pull_force;
                  if (timer_in >= TIMER_W'(cfg.pull_time)) begin
                     phase_in = PH_HOLD;
                  end
               end
               PH_HOLD: begin
                  target_in = cfg.hold_force;
                  if (timer_wide >= end_hold) begin
                     phase_in = PH_RELEASE;
                  end
               end
               PH_RELEASE: begin
                  target_in = cfg.release_force;
                  if (timer_wide >= end_release) begin
                     phase_in = PH_OFF;
                  end
               end
               PH_OFF: begin
                  target_in = '0;
               end
               default: begin
                  target_in = target_ff;
               end
            endcase
         end
      end
   end

   // bridge direction with deadband brake
   always_comb begin
      held_in        = held_ff;
      result.drive_a = 1'b0;
      result.drive_b = 1'b0;
      if (drive_in > BAND_POS) begin
         result.drive_b = 1'b1;
         held_in        = drive_in[DUTY_W-1:0];
      end else if (drive_in < BAND_NEG) begin
         result.drive_a = 1'b1;
         held_in        = drive_neg[DUTY_W-1:0];
      end
      result.duty      = held_in;
      result.heartbeat = led_in;
      result.phase     = armed_in ? phase_in : PH_NONE;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         beat_ff     <= '0;
         timer_ff    <= '0;
         push_ff     <= '0;
         armed_ff    <= 1'b0;
         phase_ff    <= PH_NONE;
         target_ff   <= '0;
         drive_ff    <= '0;
         held_ff     <= '0;
         led_ff      <= 1'b0;
      end else if (step) begin
         prescale_ff <= prescale_in;
         beat_ff     <= beat_in;
         timer_ff    <= timer_in;
         push_ff     <= push_in;
         armed_ff    <= armed_in;
         phase_ff    <= phase_in;
         target_ff   <= target_in;
         drive_ff    <= drive_in;
         held_ff     <= held_in;
         led_ff      <= led_in;
      end
   end

endmodule

/* rtl/ppds_checker.sv */
// port-level checks for the sequencer and the bind that attaches them
`include "assert_macros.svh"

module ppds_checker
   import ppds_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               drive_a,
   input logic               drive_b,
   input logic [DUTY_W-1:0]  duty,
   input logic [PHASE_W-1:0] phase
);

   // reset leaves no response pending
   `PPDS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   // bridge never drives both legs
   `PPDS_ASSERT_RST(a_no_shoot, clock, reset, rsp_valid |-> !(drive_a && drive_b), "both legs driven")

   // a driven leg means a level outside the deadband
   `PPDS_ASSERT_RST(a_duty_band, clock, reset, rsp_valid && (drive_a || drive_b) |-> duty > DUTY_W'(DEADBAND), "duty inside deadband while driving")

   // phase code stays within the defined phases
   `PPDS_ASSERT_RST(a_phase_range, clock, reset, rsp_valid |-> phase <= PH_OFF, "phase code out of range")

   // a stalled response stays valid and holds its duty
   `PPDS_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty), "stalled response changed")

endmodule

bind pendulum_pulse_drive_sequencer ppds_checker u_ppds_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .drive_a   (rsp_chan.drive_a),
   .drive_b   (rsp_chan.drive_b),
   .duty      (rsp_chan.duty),
   .phase     (rsp_chan.phase)
);
